>>> rtl/can_output_command_supervisor_core_macros.svh
// Assertion macros shared by the supervisor RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef CAN_OUTPUT_COMMAND_SUPERVISOR_CORE_MACROS_SVH
`define CAN_OUTPUT_COMMAND_SUPERVISOR_CORE_MACROS_SVH

// a holds -> b holds in the same cycle
`define COCS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("cocs assertion failed");

// a holds -> b holds in the next cycle
`define COCS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("cocs assertion failed");

`endif

>>> rtl/cocs_pkg.sv
// Types and constants for the CAN output command supervisor.
// No dependencies; imported by all supervisor modules.
package cocs_pkg;

	localparam int MASK_W = 4;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_MODE  = 2'd2;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_KEYPAD = 2'd2;
	localparam logic [1:0] MODE_DIGOUT = 2'd3;

	localparam logic [1:0] REG_DIGOUT_ID = 2'd0;
	localparam logic [1:0] REG_KEYPAD_NODE = 2'd1;
	localparam logic [1:0] REG_DIGOUT_TO = 2'd2;
	localparam logic [1:0] REG_HB_TO = 2'd3;

	localparam logic [10:0] PDO_BASE  = 11'h180;
	localparam logic [10:0] BOOT_BASE = 11'h700;
	localparam logic [7:0]  NMT_HEARTBEAT = 8'h05;
	localparam logic [7:0]  NMT_BOOTUP    = 8'h00;
	localparam logic [3:0]  DIGOUT_LEN = 4'd8;
	localparam logic [3:0]  MIN_LEN    = 4'd1;
	localparam logic [15:0] SAT16 = 16'hFFFF;

	localparam logic [10:0] RST_DIGOUT_ID   = 11'd0;
	localparam logic [6:0]  RST_KEYPAD_NODE = 7'd21;
	localparam logic [15:0] RST_DIGOUT_TO   = 16'd2000;
	localparam logic [15:0] RST_HB_TO       = 16'd1500;

	typedef struct packed {
		logic [1:0]  command;
		logic [10:0] frame_id;
		logic [3:0]  frame_len;
		logic [7:0]  byte_zero;
		logic [7:0]  byte_two;
		logic [7:0]  byte_four;
		logic [7:0]  byte_six;
		logic [3:0]  overcurrent_mask;
		logic [1:0]  new_mode;
	} req_t;

	typedef struct packed {
		logic [3:0] switch_on_mask;
		logic [3:0] switch_off_mask;
		logic [3:0] fault_clear_mask;
		logic       button_report_valid;
		logic [3:0] button_mask;
		logic       keypad_init_request;
		logic       link_ok;
		logic       digout_timed_out;
		logic [1:0] input_mode;
	} rsp_t;

	typedef struct packed {
		logic digout_hit;
		logic clear_cmd;
		logic force_off;
	} lane_ctrl_t;

	typedef struct packed {
		logic on;
		logic off;
	} lane_res_t;

	typedef struct packed {
		logic [MASK_W-1:0] on;
		logic [MASK_W-1:0] off;
		logic [MASK_W-1:0] clr;
		logic              changed;
	} merge_t;

	typedef struct packed {
		logic       button_report_valid;
		logic [3:0] button_mask;
		logic       keypad_init_request;
		logic       link_ok;
		logic       digout_timed_out;
		logic [1:0] input_mode;
	} supv_stat_t;

endpackage

>>> rtl/can_output_command_supervisor_core.sv
// Top level of the CAN output command supervisor: config port, lanes, output stage.
// Depends on cocs_pkg, cocs_lane, cocs_merge, cocs_supv and the macros header.
//
// channel   handshake              payload
// in        in_valid / in_stall    in_data  (req_t)
// out       out_valid / out_stall  out_data (rsp_t)
// cfg       psel penable pwrite    paddr[3:2] register, pwdata, prdata
//
// One request per cycle while in_stall is low; its result is registered.
// All channel lanes and the supervisor state update in the accepting cycle.
// Output register plus one skid entry; in_stall rises only while the skid entry holds.
// Reset initialises valid flags and registers, not the result data; no clearing pass.
`include "can_output_command_supervisor_core_macros.svh"
module can_output_command_supervisor_core
	import cocs_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NL = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

	logic [10:0] digout_id_q;
	logic [6:0]  keypad_node_q;
	logic [15:0] digout_to_q;
	logic [15:0] hb_to_q;

	logic             accept, pop;
	lane_ctrl_t       ctrl;
	supv_stat_t       stat;
	lane_res_t [NL-1:0] lanes;
	merge_t           mrg;
	logic [MASK_W-1:0] cmd_bits;
	rsp_t             res;
	rsp_t             out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digout_id_q <= RST_DIGOUT_ID;
			keypad_node_q <= RST_KEYPAD_NODE;
			digout_to_q <= RST_DIGOUT_TO;
			hb_to_q <= RST_HB_TO;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_DIGOUT_ID: digout_id_q <= pwdata[10:0];
				REG_KEYPAD_NODE: keypad_node_q <= pwdata[6:0];
				REG_DIGOUT_TO: digout_to_q <= pwdata[15:0];
				REG_HB_TO: hb_to_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIGOUT_ID: prdata = {21'd0, digout_id_q};
			REG_KEYPAD_NODE: prdata = {25'd0, keypad_node_q};
			REG_DIGOUT_TO: prdata = {16'd0, digout_to_q};
			REG_HB_TO: prdata = {16'd0, hb_to_q};
			default: prdata = '0;
		endcase
	end

	assign accept = in_valid & ~in_stall;
	assign pop = out_valid_q & ~out_stall;
	assign in_stall = skid_valid_q;
	assign cmd_bits = {in_data.byte_six[0], in_data.byte_four[0],
		in_data.byte_two[0], in_data.byte_zero[0]};

	cocs_supv u_supv (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req(in_data),
		.digout_id(digout_id_q),
		.keypad_node(keypad_node_q),
		.digout_to(digout_to_q),
		.hb_to(hb_to_q),
		.lane_changed(mrg.changed),
		.ctrl(ctrl),
		.stat(stat)
	);

	for (genvar i = 0; i < NL; i++) begin : g_lane
		cocs_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.cmd_bit(cmd_bits[i]),
			.oc_bit(in_data.overcurrent_mask[i]),
			.res(lanes[i])
		);
	end

	cocs_merge #(.NL(NL)) u_merge (
		.lanes(lanes),
		.force_off(ctrl.force_off),
		.merged(mrg)
	);

	always_comb begin
		res.switch_on_mask = mrg.on;
		res.switch_off_mask = mrg.off;
		res.fault_clear_mask = mrg.clr;
		res.button_report_valid = stat.button_report_valid;
		res.button_mask = stat.button_mask;
		res.keypad_init_request = stat.keypad_init_request;
		res.link_ok = stat.link_ok;
		res.digout_timed_out = stat.digout_timed_out;
		res.input_mode = stat.input_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_valid_q && !pop) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (accept) begin
			if (out_valid_q && !pop) skid_q <= res;
			else out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`COCS_ASSERT_IMPLIES(a_skid_needs_main, clk, arst_n, skid_valid_q, out_valid_q)
	`COCS_ASSERT_NEXT(a_stalled_goes_skid, clk, arst_n, accept && out_valid_q && out_stall, skid_valid_q)
	`COCS_ASSERT_IMPLIES(a_on_off_disjoint, clk, arst_n, accept, (mrg.on & mrg.off) == '0)

endmodule

>>> rtl/cocs_lane.sv
// One output channel: command edge detect and fault lock.
// Depends on cocs_pkg.
module cocs_lane
	import cocs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  logic       cmd_bit,
	input  logic       oc_bit,
	output lane_res_t  res
);

	logic prev_q;
	logic lock_q;

	always_comb begin
		res.on  = ctrl.digout_hit & cmd_bit & ~prev_q & ~lock_q;
		res.off = ctrl.digout_hit & ~cmd_bit & prev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			lock_q <= 1'b0;
		end else if (ctrl.clear_cmd) begin
			prev_q <= 1'b0;
		end else if (ctrl.digout_hit) begin
			prev_q <= cmd_bit;
			lock_q <= (lock_q & ~res.off) | oc_bit;
		end
	end

endmodule

>>> rtl/cocs_merge.sv
// Combines lane results into the channel masks, adds forced switch-off.
// Depends on cocs_pkg.
module cocs_merge
	import cocs_pkg::*;
#(
	parameter int NL = 4
) (
	input  lane_res_t [NL-1:0] lanes,
	input  logic               force_off,
	output merge_t             merged
);

	always_comb begin
		merged = '0;
		for (int i = 0; i < NL; i++) begin
			merged.on[i]  = lanes[i].on;
			merged.off[i] = lanes[i].off | force_off;
			merged.clr[i] = lanes[i].off;
			merged.changed = merged.changed | lanes[i].on | lanes[i].off;
		end
	end

endmodule

>>> rtl/cocs_supv.sv
// Mode, watchdog counters, keypad link and frame decode.
// Depends on cocs_pkg.
module cocs_supv
	import cocs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  req_t        req,
	input  logic [10:0] digout_id,
	input  logic [6:0]  keypad_node,
	input  logic [15:0] digout_to,
	input  logic [15:0] hb_to,
	input  logic        lane_changed,
	output lane_ctrl_t  ctrl,
	output supv_stat_t  stat
);

	logic [1:0]  mode_q, mode_n;
	logic [15:0] de_q, de_n, de_inc;
	logic [15:0] he_q, he_n, he_inc;
	logic        seen_q, seen_n;
	logic        link_q, link_n;
	logic        wd_q, wd_n;
	logic [10:0] pdo_id, boot_id;
	logic        hit, clr, foff;

	always_comb begin
		pdo_id  = PDO_BASE + {4'd0, keypad_node};
		boot_id = BOOT_BASE + {4'd0, keypad_node};
		de_inc  = (de_q == SAT16) ? de_q : de_q + 16'd1;
		he_inc  = (he_q == SAT16) ? he_q : he_q + 16'd1;
		mode_n = mode_q;
		de_n = de_q;
		he_n = he_q;
		seen_n = seen_q;
		link_n = link_q;
		wd_n = wd_q;
		hit = 1'b0;
		clr = 1'b0;
		foff = 1'b0;
		stat = '0;
		case (req.command)
			CMD_TICK: begin
				de_n = de_inc;
				he_n = he_inc;
				if (mode_q == MODE_DIGOUT && de_inc > digout_to) begin
					foff = 1'b1;
					clr = 1'b1;
					wd_n = 1'b1;
					de_n = '0;
				end
				if (mode_q == MODE_KEYPAD && seen_q && he_inc > hb_to) begin
					if (link_q) foff = 1'b1;
					link_n = 1'b0;
				end
			end
			CMD_MODE: begin
				mode_n = req.new_mode;
			end
			CMD_FRAME: begin
				if (req.frame_id == digout_id && req.frame_len >= DIGOUT_LEN) begin
					hit = 1'b1;
					de_n = '0;
					wd_n = 1'b0;
					if (lane_changed) mode_n = MODE_DIGOUT;
				end else if (req.frame_id == pdo_id && req.frame_len >= MIN_LEN) begin
					stat.button_report_valid = 1'b1;
					stat.button_mask = req.byte_zero[3:0];
					if (req.byte_zero[3:0] != 4'd0) mode_n = MODE_KEYPAD;
				end else if (req.frame_id == boot_id && req.frame_len >= MIN_LEN) begin
					if (req.byte_zero == NMT_BOOTUP) begin
						stat.keypad_init_request = 1'b1;
					end else if (req.byte_zero == NMT_HEARTBEAT) begin
						he_n = '0;
						seen_n = 1'b1;
						link_n = 1'b1;
					end
				end
			end
			default: ;
		endcase
		stat.link_ok = link_n;
		stat.digout_timed_out = wd_n;
		stat.input_mode = mode_n;
		ctrl.digout_hit = accept & hit;
		ctrl.clear_cmd = accept & clr;
		ctrl.force_off = foff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			de_q <= '0;
			he_q <= '0;
			seen_q <= 1'b0;
			link_q <= 1'b1;
			wd_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			de_q <= de_n;
			he_q <= he_n;
			seen_q <= seen_n;
			link_q <= link_n;
			wd_q <= wd_n;
		end
	end

endmodule

>>> test/testbench.sv
// Self-checking testbench for can_output_command_supervisor_core.
// Drives requests and APB register writes, predicts every result in SystemVerilog and
// compares field by field. Depends on cocs_pkg and the supervisor RTL only.
module testbench;
	import cocs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [1:0] MODE_LOCAL = 2'd1;
	localparam logic [3:0] ALL_CHANNELS = 4'hF;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		req_t stim;
		bit   pinned;
		rsp_t want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall;
	rsp_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	can_output_command_supervisor_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [10:0] cfg_digout_id;
	logic [6:0]  cfg_keypad_node;
	logic [15:0] cfg_digout_timeout;
	logic [15:0] cfg_heartbeat_timeout;

	// predictor copy of the supervisor state
	logic [3:0]  cmd_history;
	logic [3:0]  fault_locks;
	logic [1:0]  mode_now;
	logic [15:0] digout_ms;
	logic [15:0] heartbeat_ms;
	logic        heartbeat_heard;
	logic        link_up;
	logic        digout_expired;

	step_row_t   directed_rows[$];
	step_row_t   offered_rows[$];
	rsp_t        expected_outputs[$];
	int unsigned mismatches;
	int unsigned accepted_count;
	int unsigned checked_count;
	int unsigned settings_count;
	bit          calm;
	bit          hold_off_req;

	function automatic rsp_t supervise(input req_t r);
		rsp_t        o;
		logic [3:0]  cmd_bits;
		logic [10:0] pdo_id;
		logic [10:0] boot_id;
		o = '0;
		case (r.command)
		CMD_TICK: begin
			if (digout_ms != SAT16)
				digout_ms++;
			if (heartbeat_ms != SAT16)
				heartbeat_ms++;
			if (mode_now == MODE_DIGOUT && digout_ms > cfg_digout_timeout) begin
				o.switch_off_mask |= ALL_CHANNELS;
				cmd_history = '0;
				digout_expired = 1'b1;
				digout_ms = '0;
			end
			if (mode_now == MODE_KEYPAD && heartbeat_heard &&
			    heartbeat_ms > cfg_heartbeat_timeout) begin
				if (link_up)
					o.switch_off_mask |= ALL_CHANNELS;
				link_up = 1'b0;
			end
		end
		CMD_MODE: mode_now = r.new_mode;
		CMD_FRAME: begin
			if (r.frame_id == cfg_digout_id && r.frame_len >= DIGOUT_LEN) begin
				cmd_bits = {r.byte_six[0], r.byte_four[0], r.byte_two[0], r.byte_zero[0]};
				for (int ch = 0; ch < MASK_W; ch++) begin
					if (cmd_bits[ch] && !cmd_history[ch] && !fault_locks[ch]) begin
						o.switch_on_mask[ch] = 1'b1;
						mode_now = MODE_DIGOUT;
					end else if (!cmd_bits[ch] && cmd_history[ch]) begin
						o.switch_off_mask[ch] = 1'b1;
						o.fault_clear_mask[ch] = 1'b1;
						fault_locks[ch] = 1'b0;
						mode_now = MODE_DIGOUT;
					end
				end
				cmd_history = cmd_bits;
				digout_ms = '0;
				digout_expired = 1'b0;
				fault_locks |= r.overcurrent_mask;
			end else begin
				pdo_id = PDO_BASE + {4'd0, cfg_keypad_node};
				boot_id = BOOT_BASE + {4'd0, cfg_keypad_node};
				if (r.frame_id == pdo_id && r.frame_len >= MIN_LEN) begin
					o.button_report_valid = 1'b1;
					o.button_mask = r.byte_zero[3:0];
					if (r.byte_zero[3:0] != 4'h0)
						mode_now = MODE_KEYPAD;
				end else if (r.frame_id == boot_id && r.frame_len >= MIN_LEN &&
				             r.byte_zero == NMT_BOOTUP) begin
					o.keypad_init_request = 1'b1;
				end else if (r.frame_id == boot_id && r.frame_len >= MIN_LEN &&
				             r.byte_zero == NMT_HEARTBEAT) begin
					heartbeat_ms = '0;
					heartbeat_heard = 1'b1;
					link_up = 1'b1;
				end
			end
		end
		default: ;
		endcase
		o.link_ok = link_up;
		o.digout_timed_out = digout_expired;
		o.input_mode = mode_now;
		return o;
	endfunction

	function automatic req_t frame_req(input logic [10:0] id, input logic [3:0] len,
	                                   input logic [7:0] b0, input logic [7:0] b2,
	                                   input logic [7:0] b4, input logic [7:0] b6,
	                                   input logic [3:0] oc);
		req_t r;
		r = '0;
		r.command = CMD_FRAME;
		r.frame_id = id;
		r.frame_len = len;
		r.byte_zero = b0;
		r.byte_two = b2;
		r.byte_four = b4;
		r.byte_six = b6;
		r.overcurrent_mask = oc;
		return r;
	endfunction

	function automatic req_t control_req(input logic [1:0] cmd, input logic [1:0] nmode);
		req_t r;
		r = '0;
		r.command = cmd;
		r.new_mode = nmode;
		return r;
	endfunction

	function automatic rsp_t outcome(input logic [3:0] on, input logic [3:0] off,
	                                 input logic [3:0] clr, input logic bvalid,
	                                 input logic [3:0] buttons, input logic init,
	                                 input logic link, input logic expired,
	                                 input logic [1:0] mode);
		rsp_t o;
		o.switch_on_mask = on;
		o.switch_off_mask = off;
		o.fault_clear_mask = clr;
		o.button_report_valid = bvalid;
		o.button_mask = buttons;
		o.keypad_init_request = init;
		o.link_ok = link;
		o.digout_timed_out = expired;
		o.input_mode = mode;
		return o;
	endfunction

	function automatic step_row_t checked_by_model(input req_t r);
		step_row_t row;
		row.stim = r;
		row.pinned = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic step_row_t pinned_to(input req_t r, input rsp_t w);
		step_row_t row;
		row.stim = r;
		row.pinned = 1'b1;
		row.want = w;
		return row;
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		r.command = CMD_FRAME;
		r.frame_id = 11'($urandom_range(2047));
		r.frame_len = 4'($urandom_range(15));
		r.byte_zero = 8'($urandom);
		r.byte_two = 8'($urandom);
		r.byte_four = 8'($urandom);
		r.byte_six = 8'($urandom);
		r.overcurrent_mask = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h0;
		r.new_mode = 2'($urandom);
		pick = $urandom_range(99);
		if (pick < 4) begin
			r.command = CMD_UNKNOWN;
		end else if (pick < 12) begin
			r.command = CMD_MODE;
		end else if (pick < 45) begin
			r.command = CMD_TICK;
		end else begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				r.frame_id = cfg_digout_id;
				pick = $urandom_range(99);
				if (pick < 70)
					r.frame_len = DIGOUT_LEN;
				else if (pick < 85)
					r.frame_len = 4'($urandom_range(15, 9));
				else
					r.frame_len = 4'($urandom_range(7));
			end else if (pick < 60) begin
				r.frame_id = PDO_BASE + {4'd0, cfg_keypad_node};
				if ($urandom_range(3) == 0)
					r.byte_zero[3:0] = 4'h0;
			end else if (pick < 85) begin
				r.frame_id = BOOT_BASE + {4'd0, cfg_keypad_node};
				pick = $urandom_range(9);
				if (pick < 4)
					r.byte_zero = NMT_BOOTUP;
				else if (pick < 8)
					r.byte_zero = NMT_HEARTBEAT;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ns mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
	                           input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	task automatic compare_result(input rsp_t got, input rsp_t want);
		checked_count++;
		check_field("switch_on_mask", 32'(got.switch_on_mask), 32'(want.switch_on_mask));
		check_field("switch_off_mask", 32'(got.switch_off_mask), 32'(want.switch_off_mask));
		check_field("fault_clear_mask", 32'(got.fault_clear_mask),
		            32'(want.fault_clear_mask));
		check_field("button_report_valid", 32'(got.button_report_valid),
		            32'(want.button_report_valid));
		check_field("button_mask", 32'(got.button_mask), 32'(want.button_mask));
		check_field("keypad_init_request", 32'(got.keypad_init_request),
		            32'(want.keypad_init_request));
		check_field("link_ok", 32'(got.link_ok), 32'(want.link_ok));
		check_field("digout_timed_out", 32'(got.digout_timed_out),
		            32'(want.digout_timed_out));
		check_field("input_mode", 32'(got.input_mode), 32'(want.input_mode));
	endtask

	always @(posedge clk) begin : scoreboard
		rsp_t      predicted;
		step_row_t row;
		if (arst_n && in_valid && !in_stall) begin
			accepted_count++;
			predicted = supervise(in_data);
			row = offered_rows.pop_front();
			expected_outputs.push_back(row.pinned ? row.want : predicted);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outputs.size() == 0)
				report_mismatch("result with no request pending", 32'(out_data), 32'd0);
			else
				compare_result(out_data, expected_outputs.pop_front());
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && $urandom_range(99) < 13;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_request(input step_row_t row);
		offered_rows.push_back(row);
		while (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= row.stim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_request(checked_by_model(random_request()));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_outputs.size() != 0 || offered_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (index)
		REG_DIGOUT_ID: cfg_digout_id = value[10:0];
		REG_KEYPAD_NODE: cfg_keypad_node = value[6:0];
		REG_DIGOUT_TO: cfg_digout_timeout = value[15:0];
		REG_HB_TO: cfg_heartbeat_timeout = value[15:0];
		default: ;
		endcase
	endtask

	// upper data bits carry noise; only the register width may be kept
	task automatic program_registers(input logic [10:0] id, input logic [6:0] node,
	                                 input logic [15:0] dto, input logic [15:0] hto);
		wait_for_results();
		write_register(REG_DIGOUT_ID, {21'($urandom), id});
		write_register(REG_KEYPAD_NODE, {25'($urandom), node});
		write_register(REG_DIGOUT_TO, {16'($urandom), dto});
		write_register(REG_HB_TO, {16'($urandom), hto});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_count++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		cfg_digout_id = RST_DIGOUT_ID;
		cfg_keypad_node = RST_KEYPAD_NODE;
		cfg_digout_timeout = RST_DIGOUT_TO;
		cfg_heartbeat_timeout = RST_HB_TO;
		cmd_history = '0;
		fault_locks = '0;
		mode_now = MODE_NONE;
		digout_ms = '0;
		heartbeat_ms = '0;
		heartbeat_heard = 1'b0;
		link_up = 1'b1;
		digout_expired = 1'b0;
		settings_count = 1;

		// rows at reset settings: digout id 0, keypad node 21
		directed_rows.push_back(pinned_to(control_req(CMD_UNKNOWN, MODE_DIGOUT),
			outcome(4'h0, 4'h0, 4'h0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_NONE)));
		directed_rows.push_back(pinned_to(frame_req(11'h000, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h0),
			outcome(4'hF, 4'h0, 4'h0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_DIGOUT)));
		directed_rows.push_back(pinned_to(frame_req(11'h000, 4'd8, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 4'hF),
			outcome(4'h0, 4'hF, 4'hF, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_DIGOUT)));
		// rising edges while locked
		directed_rows.push_back(pinned_to(frame_req(11'h000, 4'd15, 8'h01, 8'h01, 8'h01, 8'h01, 4'h0),
			outcome(4'h0, 4'h0, 4'h0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_DIGOUT)));
		directed_rows.push_back(pinned_to(frame_req(11'h000, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0),
			outcome(4'h0, 4'hF, 4'hF, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_DIGOUT)));
		directed_rows.push_back(pinned_to(frame_req(11'h000, 4'd8, 8'h01, 8'h00, 8'h01, 8'h00, 4'h1),
			outcome(4'h5, 4'h0, 4'h0, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0, MODE_DIGOUT)));
		// short digout frame falls through to keypad handling
		directed_rows.push_back(checked_by_model(frame_req(11'h000, 4'd7, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0)));
		directed_rows.push_back(pinned_to(frame_req(11'h195, 4'd1, 8'hFA, 8'h00, 8'h00, 8'h00, 4'h0),
			outcome(4'h0, 4'h0, 4'h0, 1'b1, 4'hA, 1'b0, 1'b1, 1'b0, MODE_KEYPAD)));
		directed_rows.push_back(checked_by_model(frame_req(11'h195, 4'd0, 8'h0F, 8'h00, 8'h00, 8'h00, 4'h0)));
		directed_rows.push_back(checked_by_model(frame_req(11'h195, 4'd8, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 4'h0)));
		directed_rows.push_back(pinned_to(frame_req(11'h715, 4'd8, NMT_BOOTUP, 8'h00, 8'h00, 8'h00, 4'h0),
			outcome(4'h0, 4'h0, 4'h0, 1'b0, 4'h0, 1'b1, 1'b1, 1'b0, MODE_KEYPAD)));
		directed_rows.push_back(checked_by_model(frame_req(11'h715, 4'd1, NMT_HEARTBEAT, 8'h00, 8'h00, 8'h00, 4'h0)));
		directed_rows.push_back(checked_by_model(frame_req(11'h715, 4'd1, 8'h07, 8'h00, 8'h00, 8'h00, 4'h0)));
		directed_rows.push_back(checked_by_model(frame_req(11'h715, 4'd0, NMT_BOOTUP, 8'h00, 8'h00, 8'h00, 4'h0)));
		directed_rows.push_back(checked_by_model(frame_req(11'h7FF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF)));
		directed_rows.push_back(checked_by_model(control_req(CMD_TICK, MODE_NONE)));
		directed_rows.push_back(checked_by_model(control_req(CMD_MODE, MODE_LOCAL)));
		directed_rows.push_back(checked_by_model(control_req(CMD_MODE, MODE_NONE)));
		directed_rows.push_back(checked_by_model(control_req(CMD_MODE, MODE_DIGOUT)));
		directed_rows.push_back(checked_by_model(frame_req(11'h000, 4'd8, 8'h00, 8'h01, 8'h00, 8'h01, 4'h0)));
		directed_rows.push_back(checked_by_model(control_req(CMD_TICK, MODE_KEYPAD)));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_request(directed_rows[i]);

		program_registers(11'($urandom), 7'($urandom), 16'($urandom_range(6, 1)),
		                  16'($urandom_range(6, 1)));
		hold_off_req = 1'b1;
		send_random(450);

		program_registers(11'h7FF, 7'h7F, 16'd1, 16'd1);
		send_random(350);

		// digout frame id equal to the keypad PDO id
		program_registers(PDO_BASE, 7'h00, 16'd12, 16'd9);
		calm = 1'b1;
		send_random(300);
		calm = 1'b0;
		send_random(100);

		program_registers(11'($urandom), 7'($urandom), 16'hFFFF, 16'hFFFF);
		send_random(200);

		program_registers(11'($urandom), 7'($urandom), 16'($urandom_range(30, 1)),
		                  16'($urandom_range(30, 1)));
		send_random(400);

		wait_for_results();
		$display("Covered %0d requests, %0d results checked, over %0d register settings.",
		         accepted_count, checked_count, settings_count);
		$display("Included a long output hold-off that filled the skid stage; %0d mismatches.",
		         mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
